// File: rtl/core/ahps_pkg.sv
// shared types and codes of the actuator homing and position sequencer
// event kinds, result action codes, register map and one-hot state encodings
// no dependencies
package ahps_pkg;

	localparam int POS_W   = 24;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	// event kinds
	localparam logic [2:0] KIND_TICK     = 3'd0;
	localparam logic [2:0] KIND_HOME     = 3'd1;
	localparam logic [2:0] KIND_ENABLE   = 3'd2;
	localparam logic [2:0] KIND_DISABLE  = 3'd3;
	localparam logic [2:0] KIND_TARGET   = 3'd4;
	localparam logic [2:0] KIND_HOME_ERR = 3'd5;

	// motor driver commands
	localparam logic [2:0] MOT_NONE       = 3'd0;
	localparam logic [2:0] MOT_SET_RPM    = 3'd1;
	localparam logic [2:0] MOT_RPM_UPDATE = 3'd2;
	localparam logic [2:0] MOT_UPDATE     = 3'd3;
	localparam logic [2:0] MOT_STOP       = 3'd4;

	// pid commands
	localparam logic [1:0] PID_NONE    = 2'd0;
	localparam logic [1:0] PID_RESET   = 2'd1;
	localparam logic [1:0] PID_COMPUTE = 2'd2;
	localparam logic [1:0] PID_REUSE   = 2'd3;

	// encoder commands
	localparam logic [1:0] ENC_NONE       = 2'd0;
	localparam logic [1:0] ENC_READ_RESET = 2'd1;
	localparam logic [1:0] ENC_WRITE_ZERO = 2'd2;

	// reported mode codes
	localparam logic [2:0] MODE_CODE_IDLE     = 3'd0;
	localparam logic [2:0] MODE_CODE_HOMING   = 3'd1;
	localparam logic [2:0] MODE_CODE_DISABLED = 3'd2;
	localparam logic [2:0] MODE_CODE_CONTROL  = 3'd3;
	localparam logic [2:0] MODE_CODE_FAILURE  = 3'd4;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_HOME_BY_SWITCH = 3'd0;
	localparam logic [2:0] REG_HOMING_SPEED   = 3'd1;
	localparam logic [2:0] REG_MAX_TRAVEL     = 3'd2;
	localparam logic [2:0] REG_DEADBAND       = 3'd3;
	localparam logic [2:0] REG_STALL_MOTION   = 3'd4;
	localparam logic [2:0] REG_STALL_TICKS    = 3'd5;
	localparam logic [2:0] REG_SETTLE_TICKS   = 3'd6;

	typedef enum logic [4:0] {
		MM_IDLE     = 5'b00001,
		MM_HOMING   = 5'b00010,
		MM_DISABLED = 5'b00100,
		MM_CONTROL  = 5'b01000,
		MM_FAILURE  = 5'b10000
	} main_mode_t;

	typedef enum logic [3:0] {
		PH_INIT     = 4'b0001,
		PH_SEARCH   = 4'b0010,
		PH_SETTLE   = 4'b0100,
		PH_FINISHED = 4'b1000
	} phase_t;

endpackage

// File: rtl/core/actuator_homing_and_position_sequencer.sv
// top level of the actuator homing and position sequencer
// holds the apb register file, the event register, the sequencer state and the result register
// depends on ahps_pkg
//
// Each event beat is registered, handled by the sequencer logic, and the single result
// beat is captured in an output register, so the block takes one event per clock as
// long as the result side keeps taking beats. That rate is bounded by the sequencer
// state (mode, homing phase, stall and settle counters, target), which every event
// reads and updates. PID and motor driver live outside; their commands come out as
// fields of the result. Registers must be written over the apb port only while no
// event is in flight; the block itself does not enforce this. Writing max_travel
// also reloads the working travel limit.
module actuator_homing_and_position_sequencer
	import ahps_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// apb configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	// event channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               kind,
	input  logic signed [POS_W-1:0]  encoder_position,
	input  logic                     limit_switch_level,
	input  logic signed [POS_W-1:0]  requested_target,
	input  logic                     motor_changing_direction,
	// result channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [2:0]               motor_action,
	output logic signed [16:0]       rpm_value,
	output logic [1:0]               pid_action,
	output logic signed [POS_W-1:0]  pid_setpoint,
	output logic signed [POS_W-1:0]  pid_measurement,
	output logic [1:0]               encoder_action,
	output logic [2:0]               mode,
	output logic                     is_homed,
	output logic signed [POS_W-1:0]  target_position,
	output logic                     accepted
);

	// configuration registers
	logic               home_by_switch_q;
	logic [15:0]        homing_speed_q;
	logic [22:0]        max_travel_q;
	logic signed [16:0] deadband_q;
	logic [15:0]        stall_motion_q;
	logic [15:0]        stall_ticks_q;
	logic [15:0]        settle_ticks_q;

	// sequencer state
	main_mode_t         mode_q, mode_d;
	phase_t             phase_q, phase_d;
	logic               homed_q, homed_d;
	logic signed [POS_W:0] target_q, target_d;  // one extra bit: clamp may reach 2^23
	logic [POS_W-1:0]   wmax_q, wmax_d;
	logic [POS_W-1:0]   lpp_q, lpp_d;
	logic [15:0]        stall_q, stall_d;
	logic [15:0]        settle_q, settle_d;

	// event register
	logic                    valid_s1;
	logic [2:0]              kind_s1;
	logic signed [POS_W-1:0] enc_s1;
	logic                    sw_s1;
	logic signed [POS_W-1:0] req_s1;
	logic                    chg_s1;

	// result register
	logic                    out_valid_q;
	logic [2:0]              motor_q, motor_d;
	logic signed [16:0]      rpm_q, rpm_d;
	logic [1:0]              pid_q, pid_d;
	logic signed [POS_W-1:0] sp_q, sp_d;
	logic signed [POS_W-1:0] meas_q, meas_d;
	logic [1:0]              encact_q, encact_d;
	logic [2:0]              mode_code_q, mode_code_d;
	logic                    homed_out_q;
	logic signed [POS_W-1:0] target_out_q;
	logic                    acc_q, acc_d;

	logic cfg_wr;
	logic advance;

	// datapath helpers
	logic [POS_W-1:0]        enc_abs;
	logic [POS_W-1:0]        wmax_new;
	logic signed [POS_W:0]   progress;
	logic                    moved;
	logic [15:0]             stall_next;
	logic                    home_hit;
	logic signed [POS_W+1:0] err;
	logic [POS_W+1:0]        err_abs;
	logic                    pid_run;
	logic                    req_over;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_by_switch_q <= 1'b1;
			homing_speed_q   <= 16'd30;
			max_travel_q     <= 23'd4096;
			deadband_q       <= -17'sd1;
			stall_motion_q   <= 16'd5;
			stall_ticks_q    <= 16'd20;
			settle_ticks_q   <= 16'd20;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_HOME_BY_SWITCH: home_by_switch_q <= pwdata[0];
				REG_HOMING_SPEED:   homing_speed_q   <= pwdata[15:0];
				REG_MAX_TRAVEL:     max_travel_q     <= pwdata[22:0];
				REG_DEADBAND:       deadband_q       <= pwdata[16:0];
				REG_STALL_MOTION:   stall_motion_q   <= pwdata[15:0];
				REG_STALL_TICKS:    stall_ticks_q    <= pwdata[15:0];
				REG_SETTLE_TICKS:   settle_ticks_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register read
	always_comb begin
		case (paddr[4:2])
			REG_HOME_BY_SWITCH: prdata = {31'd0, home_by_switch_q};
			REG_HOMING_SPEED:   prdata = {16'd0, homing_speed_q};
			REG_MAX_TRAVEL:     prdata = {9'd0, max_travel_q};
			REG_DEADBAND:       prdata = {{15{deadband_q[16]}}, deadband_q};
			REG_STALL_MOTION:   prdata = {16'd0, stall_motion_q};
			REG_STALL_TICKS:    prdata = {16'd0, stall_ticks_q};
			REG_SETTLE_TICKS:   prdata = {16'd0, settle_ticks_q};
			default:            prdata = '0;
		endcase
	end

	// handshake: the result register frees up in the same cycle it is taken
	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1  <= kind;
			enc_s1   <= encoder_position;
			sw_s1    <= limit_switch_level;
			req_s1   <= requested_target;
			chg_s1   <= motor_changing_direction;
		end
	end

	// homing search arithmetic
	always_comb begin
		enc_abs    = enc_s1[POS_W-1] ? (-enc_s1) : enc_s1;
		wmax_new   = (enc_abs > wmax_q) ? enc_abs : wmax_q;
		progress   = $signed({1'b0, wmax_new}) - $signed({1'b0, lpp_q});
		moved      = progress > $signed({{(POS_W-15){1'b0}}, stall_motion_q});
		if (moved) begin
			stall_next = '0;
		end else if (stall_q != 16'hFFFF) begin
			stall_next = stall_q + 16'd1;
		end else begin
			stall_next = stall_q;
		end
		home_hit = home_by_switch_q ? ~sw_s1 : (stall_next > stall_ticks_q);
	end

	// position control arithmetic
	always_comb begin
		err      = {target_q[POS_W], target_q} - {{2{enc_s1[POS_W-1]}}, enc_s1};
		err_abs  = err[POS_W+1] ? (-err) : err;
		pid_run  = deadband_q[16] || (err_abs > {{(POS_W-14){1'b0}}, deadband_q[15:0]});
		req_over = req_s1 > $signed({1'b0, wmax_q});
	end

	// sequencer
	always_comb begin
		mode_d   = mode_q;
		phase_d  = phase_q;
		homed_d  = homed_q;
		target_d = target_q;
		wmax_d   = wmax_q;
		lpp_d    = lpp_q;
		stall_d  = stall_q;
		settle_d = settle_q;
		motor_d  = MOT_NONE;
		rpm_d    = '0;
		pid_d    = PID_NONE;
		sp_d     = '0;
		meas_d   = '0;
		encact_d = ENC_NONE;
		acc_d    = 1'b1;

		case (kind_s1)
			KIND_TICK: begin
				if (mode_q == MM_HOMING) begin
					case (phase_q)
						PH_SEARCH: begin
							wmax_d  = wmax_new;
							stall_d = stall_next;
							if (moved) begin
								lpp_d = wmax_new;
							end
							if (home_hit) begin
								motor_d  = MOT_STOP;
								phase_d  = PH_SETTLE;
								settle_d = '0;
							end else begin
								motor_d = MOT_RPM_UPDATE;
								rpm_d   = -$signed({1'b0, homing_speed_q});
							end
						end
						PH_SETTLE: begin
							if (settle_q >= settle_ticks_q) begin
								// homing done: zero the encoder and go to control
								encact_d = ENC_WRITE_ZERO;
								target_d = '0;
								phase_d  = PH_FINISHED;
								homed_d  = 1'b1;
								mode_d   = MM_CONTROL;
							end else begin
								settle_d = settle_q + 16'd1;
								motor_d  = MOT_UPDATE;
							end
						end
						default: begin
							// init, also a finished phase seen again
							homed_d  = 1'b0;
							target_d = '0;
							lpp_d    = '0;
							stall_d  = '0;
							phase_d  = PH_SEARCH;
							motor_d  = MOT_SET_RPM;
							pid_d    = PID_RESET;
							encact_d = ENC_READ_RESET;
						end
					endcase
				end else if (mode_q == MM_CONTROL) begin
					motor_d = MOT_RPM_UPDATE;
					if (pid_run) begin
						if (chg_s1) begin
							pid_d = PID_REUSE;
						end else begin
							pid_d  = PID_COMPUTE;
							sp_d   = target_q[POS_W-1:0];
							meas_d = enc_s1;
						end
					end else begin
						pid_d = PID_RESET;
					end
				end
			end
			KIND_HOME: begin
				mode_d  = MM_HOMING;
				phase_d = PH_INIT;
				homed_d = 1'b0;
			end
			KIND_ENABLE: begin
				if (!homed_q) begin
					acc_d = 1'b0;
				end else begin
					target_d = {enc_s1[POS_W-1], enc_s1};
					mode_d   = MM_CONTROL;
				end
			end
			KIND_DISABLE: begin
				motor_d = MOT_RPM_UPDATE;
				mode_d  = homed_q ? MM_DISABLED : MM_IDLE;
			end
			KIND_TARGET: begin
				if (req_s1[POS_W-1]) begin
					target_d = '0;
				end else if (req_over) begin
					target_d = {1'b0, wmax_q};
				end else begin
					target_d = {1'b0, req_s1};
				end
			end
			KIND_HOME_ERR: begin
				mode_d = MM_FAILURE;
			end
			default: ;
		endcase

		case (mode_d)
			MM_IDLE:     mode_code_d = MODE_CODE_IDLE;
			MM_HOMING:   mode_code_d = MODE_CODE_HOMING;
			MM_DISABLED: mode_code_d = MODE_CODE_DISABLED;
			MM_CONTROL:  mode_code_d = MODE_CODE_CONTROL;
			MM_FAILURE:  mode_code_d = MODE_CODE_FAILURE;
			default:     mode_code_d = MODE_CODE_IDLE;
		endcase
	end

	// sequencer state update; a max_travel write reloads the working limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MM_IDLE;
			phase_q  <= PH_INIT;
			homed_q  <= 1'b0;
			target_q <= '0;
			wmax_q   <= 24'd4096;
			lpp_q    <= '0;
			stall_q  <= '0;
			settle_q <= '0;
		end else if (cfg_wr && paddr[4:2] == REG_MAX_TRAVEL) begin
			wmax_q <= {1'b0, pwdata[22:0]};
		end else if (advance) begin
			mode_q   <= mode_d;
			phase_q  <= phase_d;
			homed_q  <= homed_d;
			target_q <= target_d;
			wmax_q   <= wmax_d;
			lpp_q    <= lpp_d;
			stall_q  <= stall_d;
			settle_q <= settle_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			motor_q      <= motor_d;
			rpm_q        <= rpm_d;
			pid_q        <= pid_d;
			sp_q         <= sp_d;
			meas_q       <= meas_d;
			encact_q     <= encact_d;
			mode_code_q  <= mode_code_d;
			homed_out_q  <= homed_d;
			target_out_q <= target_d[POS_W-1:0];
			acc_q        <= acc_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign motor_action    = motor_q;
	assign rpm_value       = rpm_q;
	assign pid_action      = pid_q;
	assign pid_setpoint    = sp_q;
	assign pid_measurement = meas_q;
	assign encoder_action  = encact_q;
	assign mode            = mode_code_q;
	assign is_homed        = homed_out_q;
	assign target_position = target_out_q;
	assign accepted        = acc_q;

endmodule
